// ----- design/ps2_mouse_packet_cursor_tracker_core_defines.svh -----
// Assertion macros shared by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMPCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMPCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pmpct_pkg.sv -----
package pmpct_pkg;

    // Width of the screen size registers.
    localparam int CFG_BITS = 13;
    localparam int CFG_DATA_BITS = 32;

    // Sync marker in the first byte of a packet.
    localparam int SYNC_BIT_IDX = 3;
    localparam logic [7:0] SYNC_MASK = 8'h08;

    // Cursor sprite geometry that sets the edge clamps.
    localparam int SPRITE_WIDTH = 32;
    localparam int SPRITE_HEIGHT = 32;
    localparam int EDGE_TEST = SPRITE_WIDTH - 16;
    localparam int EDGE_SET = (SPRITE_WIDTH / 2) - 4;

    // Register index, taken from paddr[2].
    localparam logic REG_IDX_WIDTH = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET = 13'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_DX   = 2'd1,
        PH_DY   = 2'd2
    } phase_t;

endpackage

// ----- design/ps2_mouse_packet_cursor_tracker_core.sv -----
// PS/2 mouse packet decoder with cursor position tracking.
//
// Input channel (s_*): one controller byte per item in s_tdata, s_tuser set when
// the byte came from the auxiliary (mouse) port. Other bytes are dropped. Mouse
// bytes are framed into three-byte packets; a first byte without its sync bit
// is discarded. Bytes two and three are signed dx and dy.
// Output channel (m_*): one item per completed packet with nonzero motion,
// carrying the clamped cursor column and row.
// Configuration: APB port with screen width at 0x0 and screen height at 0x4;
// write only while the block is idle.
//
// The third byte's result is registered, in the result register or else the skid.
// Throughput: one item per cycle while the skid is empty; the cursor update is a
// single add-clamp pass between the accept edge and the result register.
// Stall: a two-entry output buffer (result register plus skid) keeps s_tready
// high while one result waits; s_tready drops only when both entries are full.
// Reset: phase back to waiting for sync, cursor at (0,0), width 640, height
// 480, output buffer empty. No clearing pass is needed.
module ps2_mouse_packet_cursor_tracker_core
    import pmpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input item
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] byte_in
    input  logic                      s_tuser,   // [0] from_mouse
    // result item
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata, // pos_x, pos_y, zero fill
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [CFG_DATA_BITS-1:0]  pwdata,
    output logic [CFG_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    // Signed working width: room for the coordinate or the screen size plus sign and carry.
    localparam int SW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam logic signed [SW-1:0] EDGE_TEST_S = SW'(EDGE_TEST);
    localparam logic signed [SW-1:0] EDGE_SET_S = SW'(EDGE_SET);
    localparam logic signed [SW-1:0] CUR_H_S = SW'(SPRITE_HEIGHT);
    localparam logic signed [SW-1:0] COORD_MAX_S = SW'((64'd1 << COORD_BITS) - 64'd1);

    // configuration registers
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;

    // packet state
    phase_t phase_reg, phase_next;
    logic [7:0] held_dx_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;

    // output buffer: result register and skid entry
    logic out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic skid_valid_reg;
    logic [COORD_BITS-1:0] skid_x_reg;
    logic [COORD_BITS-1:0] skid_y_reg;

    logic accept;
    logic mouse_accept;
    logic pkt_end;
    logic emit;
    logic pop;
    logic cfg_write;

    logic signed [SW-1:0] dx_s, dy_s, col_s, row_s, w_s, h_s;
    logic signed [SW-1:0] x_sum, y_sum, x_pos, y_pos, x_edge, y_edge;
    logic [COORD_BITS-1:0] x_fit, y_fit;

    assign s_tready = !skid_valid_reg;
    assign accept = s_tvalid && s_tready;
    assign mouse_accept = accept && s_tuser;
    assign pkt_end = mouse_accept && (phase_reg == PH_DY);
    assign emit = pkt_end && ((held_dx_reg != 8'd0) || (s_tdata != 8'd0));
    assign pop = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_W'({out_y_reg, out_x_reg});

    // APB: always ready, register picked by paddr[2]
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = CFG_DATA_BITS'(width_reg);
            REG_IDX_HEIGHT: prdata = CFG_DATA_BITS'(height_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  width_reg <= pwdata[CFG_BITS-1:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[CFG_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Packet framing: the phase advances only on mouse bytes.
    always_comb
    begin
        phase_next = phase_reg;
        if (mouse_accept)
        begin
            unique case (phase_reg)
                PH_DX:   phase_next = PH_DY;
                PH_DY:   phase_next = PH_SYNC;
                default: phase_next = s_tdata[SYNC_BIT_IDX] ? PH_DX : PH_SYNC;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_SYNC;
        else
            phase_reg <= phase_next;
    end

    // Hold dx until the dy byte arrives.
    always_ff @(posedge clk)
    begin
        if (mouse_accept && (phase_reg == PH_DX))
            held_dx_reg <= s_tdata;
    end

    // Cursor move and clamp: x += dx, y -= dy, floor at zero, then screen edges,
    // then saturate into the coordinate range.
    always_comb
    begin
        dx_s = SW'($signed(held_dx_reg));
        dy_s = SW'($signed(s_tdata));
        col_s = $signed(SW'(col_reg));
        row_s = $signed(SW'(row_reg));
        w_s = $signed(SW'(width_reg));
        h_s = $signed(SW'(height_reg));

        x_sum = col_s + dx_s;
        y_sum = row_s - dy_s;
        x_pos = (x_sum < 0) ? '0 : x_sum;
        y_pos = (y_sum < 0) ? '0 : y_sum;
        x_edge = (x_pos > (w_s - EDGE_TEST_S)) ? (w_s - EDGE_SET_S) : x_pos;
        y_edge = (y_pos > (h_s - CUR_H_S)) ? (h_s - CUR_H_S) : y_pos;

        if (x_edge < 0)
            x_fit = '0;
        else if (x_edge > COORD_MAX_S)
            x_fit = COORD_MAX_S[COORD_BITS-1:0];
        else
            x_fit = x_edge[COORD_BITS-1:0];

        if (y_edge < 0)
            y_fit = '0;
        else if (y_edge > COORD_MAX_S)
            y_fit = COORD_MAX_S[COORD_BITS-1:0];
        else
            y_fit = y_edge[COORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pkt_end)
        begin
            col_reg <= x_fit;
            row_reg <= y_fit;
        end
    end

    // Output buffer. A new result goes to the result register when it is free
    // or being drained, else to the skid entry. The skid refills the result
    // register on the next pop; no new item is taken while the skid is full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || pop)
            begin
                out_x_reg <= x_fit;
                out_y_reg <= y_fit;
            end
            else
            begin
                skid_x_reg <= x_fit;
                skid_y_reg <= y_fit;
            end
        end
    end

endmodule

// ----- design/pmpct_checker.sv -----
`include "ps2_mouse_packet_cursor_tracker_core_defines.svh"

module pmpct_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata
);

    // A stalled result item holds.
    `PMPCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result item changed")

    // A new result only follows an accepted mouse byte.
    `PMPCT_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tuser), "result item without a mouse byte")

    // Input backpressure only while a result is waiting.
    `PMPCT_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result pending")

    // Draining a full buffer frees the input side on the next cycle.
    `PMPCT_ASSERT_NEXT(a_skid_drain, m_tvalid && m_tready && !s_tready, s_tready, "input still stalled after drain")

endmodule

bind ps2_mouse_packet_cursor_tracker_core pmpct_checker #(.COORD_BITS(COORD_BITS)) u_pmpct_checker (.*);
